### rtl/weather_sample_aggregator_defines.svh
// Assertion macros for the weather sample aggregator.
`ifndef WEATHER_SAMPLE_AGGREGATOR_DEFINES_SVH
`define WEATHER_SAMPLE_AGGREGATOR_DEFINES_SVH

`ifndef SYNTH
`define WSA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define WSA_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define WSA_ASSERT(lbl, prop)
`define WSA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### rtl/wsa_pkg.sv
package wsa_pkg;

   localparam int CNT_W  = 16;
   localparam int TSUM_W = 28;
   localparam int WSUM_W = 30;
   localparam int LSUM_W = 26;
   localparam int TDEN_W = CNT_W + 2;
   localparam int DEN_W  = TDEN_W + 1;
   localparam int REM_W  = 30;
   localparam int Q_W    = 14;
   localparam int DVS_W  = DEN_W + Q_W - 1;
   localparam int STEP_W = 4;

   localparam logic [CNT_W-1:0]  MAX_SAMPLES = 16'd65535;
   localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(Q_W - 1);
   localparam logic signed [11:0] TEMP_EMPTY = -12'sd2032;
   localparam int TEMP_LOW_EDGE  = 880;
   localparam int TEMP_HIGH_EDGE = 2000;

   typedef enum logic [1:0] {
      ACT_SAMPLE   = 2'd0,
      ACT_FINALIZE = 2'd1,
      ACT_CLEAR    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      JOB_TIN   = 2'd0,
      JOB_TOUT  = 2'd1,
      JOB_WIND  = 2'd2,
      JOB_LIGHT = 2'd3
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_STORE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic               temp_valid;
      logic signed [11:0] temp_in;
      logic signed [11:0] temp_out;
      logic [13:0]        wind_speed;
      logic [9:0]         light_level;
      logic [31:0]        timestamp;
   } req_type;

   typedef struct packed {
      logic [31:0]        snap_time;
      logic signed [11:0] avg_temp_in;
      logic signed [11:0] avg_temp_out;
      logic [13:0]        avg_wind;
      logic [13:0]        peak_wind;
      logic [9:0]         avg_light;
      logic               snap_valid;
   } rsp_type;

   typedef struct packed {
      logic    accept;
      logic    load;
      logic    step;
      logic    store;
      logic    emit;
      job_type job;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

### rtl/weather_sample_aggregator.sv
// Weather sample aggregator: keeps running sums of indoor/outdoor temperature,
// wind and light plus peak wind. Sample and clear requests may arrive every
// cycle while no finalize is in progress. A finalize request holds off the
// next request until it is done: its four averages run one after another
// through a single shared restoring divider at one quotient bit per cycle (per
// average: a setup step, one step per quotient bit, a store step), then a load
// of the output register. The snapshot waits in that register, and a stall
// on rsp_ready only delays a finalize that finds the register still full.
module weather_sample_aggregator
   import wsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   wsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   wsa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/wsa_ctrl.sv
`include "weather_sample_aggregator_defines.svh"

module wsa_ctrl
   import wsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_action,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_TIN;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.job    = job_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && action_type'(req_action) == ACT_FINALIZE) begin
               job_in   = JOB_TIN;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = STEP_LAST;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (job_ff == JOB_LIGHT) begin
               state_in = ST_OUT;
            end else begin
               job_in   = job_type'(job_ff + 2'd1);
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `WSA_ASSERT_NEXT(a_fin_starts_div, req_valid && req_ready && action_type'(req_action) == ACT_FINALIZE, state_ff == ST_LOAD && job_ff == JOB_TIN)
   `WSA_ASSERT_NEXT(a_div_counts_down, state_ff == ST_DIV && cnt_ff != '0, state_ff == ST_DIV && cnt_ff == $past(cnt_ff) - STEP_W'(1))
   `WSA_ASSERT_NEXT(a_last_store_out, state_ff == ST_STORE && job_ff == JOB_LIGHT, state_ff == ST_OUT)

endmodule

### rtl/wsa_dp.sv
module wsa_dp
   import wsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic signed [TSUM_W-1:0] tin_sum_ff, tout_sum_ff;
   logic [WSUM_W-1:0]        wind_sum_ff;
   logic [LSUM_W-1:0]        light_sum_ff;
   logic [CNT_W-1:0]         temp_cnt_ff, samp_cnt_ff;
   logic [13:0]              peak_ff;
   logic [31:0]              time_ff;

   logic [REM_W-1:0]         rem_ff;
   logic [DVS_W-1:0]         dvs_ff;
   logic [Q_W-1:0]           q_ff;
   logic                     neg_ff, wide_ff;

   logic signed [11:0]       res_tin_ff, res_tout_ff;
   logic [13:0]              res_wind_ff;
   logic [9:0]               res_light_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic signed [TSUM_W-1:0] t_sum;
   logic signed [TSUM_W:0]   t_x, lo_lim, hi_lim;
   logic [25:0]              lo_mag;
   logic [26:0]              hi_mag;
   logic                     t_wide;
   logic [TSUM_W-2:0]        t_mag;
   logic [TDEN_W-1:0]        t_d;
   logic [REM_W-1:0]         ld_num;
   logic [DEN_W-1:0]         ld_den;
   logic                     ge;
   logic [Q_W-1:0]           tq;
   logic [11:0]              tv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tin_sum_ff   <= '0;
         tout_sum_ff  <= '0;
         wind_sum_ff  <= '0;
         light_sum_ff <= '0;
         temp_cnt_ff  <= '0;
         samp_cnt_ff  <= '0;
         peak_ff      <= '0;
      end else if (cmd.accept) begin
         case (action_type'(req_data.action))
            ACT_SAMPLE: begin
               if (req_data.temp_valid && temp_cnt_ff != MAX_SAMPLES) begin
                  tin_sum_ff  <= tin_sum_ff + TSUM_W'(req_data.temp_in);
                  tout_sum_ff <= tout_sum_ff + TSUM_W'(req_data.temp_out);
                  temp_cnt_ff <= temp_cnt_ff + CNT_W'(1);
               end
               if (samp_cnt_ff != MAX_SAMPLES) begin
                  wind_sum_ff  <= wind_sum_ff + WSUM_W'(req_data.wind_speed);
                  light_sum_ff <= light_sum_ff + LSUM_W'(req_data.light_level);
                  samp_cnt_ff  <= samp_cnt_ff + CNT_W'(1);
               end
               if (req_data.wind_speed > peak_ff) begin
                  peak_ff <= req_data.wind_speed;
               end
            end
            ACT_CLEAR: begin
               tin_sum_ff   <= '0;
               tout_sum_ff  <= '0;
               wind_sum_ff  <= '0;
               light_sum_ff <= '0;
               temp_cnt_ff  <= '0;
               samp_cnt_ff  <= '0;
               peak_ff      <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         time_ff <= req_data.timestamp;
      end
   end

   // operand setup: temps round half away from zero as floor((2|s| + d) / 2d)
   always_comb begin
      t_sum  = (cmd.job == JOB_TOUT) ? tout_sum_ff : tin_sum_ff;
      t_x    = {t_sum[TSUM_W-1], t_sum};
      lo_mag = 26'(temp_cnt_ff) * 26'(TEMP_LOW_EDGE);
      hi_mag = 27'(temp_cnt_ff) * 27'(TEMP_HIGH_EDGE);
      lo_lim = -$signed({3'b000, lo_mag});
      hi_lim = $signed({2'b00, hi_mag});
      t_wide = (t_x <= lo_lim) || (t_x >= hi_lim);
      t_mag  = t_sum[TSUM_W-1] ? (TSUM_W-1)'(-t_sum) : (TSUM_W-1)'(t_sum);
      t_d    = t_wide ? TDEN_W'(temp_cnt_ff) : {temp_cnt_ff, 2'b00};
      case (cmd.job)
         JOB_TIN, JOB_TOUT: begin
            ld_num = REM_W'({t_mag, 1'b0}) + REM_W'(t_d);
            ld_den = {t_d, 1'b0};
         end
         JOB_WIND: begin
            ld_num = REM_W'(wind_sum_ff);
            ld_den = DEN_W'(samp_cnt_ff);
         end
         default: begin
            ld_num = REM_W'(light_sum_ff);
            ld_den = DEN_W'(samp_cnt_ff);
         end
      endcase
   end

   assign ge = {{(DVS_W-REM_W){1'b0}}, rem_ff} >= dvs_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff  <= ld_num;
         dvs_ff  <= {ld_den, {(Q_W-1){1'b0}}};
         q_ff    <= '0;
         neg_ff  <= t_sum[TSUM_W-1];
         wide_ff <= t_wide;
      end else if (cmd.step) begin
         if (ge) begin
            rem_ff <= rem_ff - dvs_ff[REM_W-1:0];
         end
         q_ff   <= {q_ff[Q_W-2:0], ge};
         dvs_ff <= dvs_ff >> 1;
      end
   end

   always_comb begin
      tq = wide_ff ? q_ff : {q_ff[Q_W-3:0], 2'b00};
      tv = neg_ff ? (~tq[11:0] + 12'd1) : tq[11:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.job)
            JOB_TIN: begin
               res_tin_ff <= (temp_cnt_ff == '0) ? TEMP_EMPTY : $signed(tv);
            end
            JOB_TOUT: begin
               res_tout_ff <= (temp_cnt_ff == '0) ? TEMP_EMPTY : $signed(tv);
            end
            JOB_WIND: begin
               res_wind_ff <= (samp_cnt_ff == '0) ? '0 : q_ff;
            end
            default: begin
               res_light_ff <= (samp_cnt_ff == '0) ? '0 : q_ff[9:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.snap_time    <= time_ff;
         rsp_data_ff.avg_temp_in  <= res_tin_ff;
         rsp_data_ff.avg_temp_out <= res_tout_ff;
         rsp_data_ff.avg_wind     <= res_wind_ff;
         rsp_data_ff.peak_wind    <= peak_ff;
         rsp_data_ff.avg_light    <= res_light_ff;
         rsp_data_ff.snap_valid   <= (samp_cnt_ff != '0) || (temp_cnt_ff != '0);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

### tb/wsa_snapshot_checker.sv
`timescale 1ns / 1ps
module wsa_snapshot_checker
   import wsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      snaps_due,
   output int      snaps_seen,
   output int      samples_seen
);

   logic signed [31:0] indoor_sum;
   logic signed [31:0] outdoor_sum;
   logic [15:0]        temp_samples;
   logic [15:0]        samples;
   logic [31:0]        wind_total;
   logic [31:0]        light_total;
   logic [13:0]        wind_max;
   rsp_type            snap_q[$];

   initial begin
      fail_count   = 0;
      snaps_due    = 0;
      snaps_seen   = 0;
      samples_seen = 0;
   end

   function automatic longint half_away(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (2 * mag + den) / (2 * den);
      return (num < 0) ? -mag : mag;
   endfunction

   // quarter-degree rounding inside (-55 C, 125 C), 1/16 C outside
   function automatic logic signed [11:0] temp_mean(logic signed [31:0] total,
                                                    logic [15:0] n);
      longint s;
      longint c;
      s = total;
      c = n;
      if (n == 0) return TEMP_EMPTY;
      if (s <= -TEMP_LOW_EDGE * c || s >= TEMP_HIGH_EDGE * c)
         return 12'(half_away(s, c));
      return 12'(4 * half_away(s, 4 * c));
   endfunction

   task automatic flag_field(string field, logic signed [63:0] want_v,
                             logic signed [63:0] got_v);
      fail_count++;
      $display("%0t: snapshot %0d %s mismatch, expected %0d, actual %0d",
               $time, snaps_seen, field, want_v, got_v);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         indoor_sum   = '0;
         outdoor_sum  = '0;
         temp_samples = '0;
         samples      = '0;
         wind_total   = '0;
         light_total  = '0;
         wind_max     = '0;
         snap_q.delete();
         snaps_due <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (snap_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected snapshot, expected none, actual %p",
                        $time, rsp_data);
            end else begin
               want = snap_q.pop_front();
               if (rsp_data.snap_time !== want.snap_time)
                  flag_field("snap_time", want.snap_time, rsp_data.snap_time);
               if (rsp_data.avg_temp_in !== want.avg_temp_in)
                  flag_field("avg_temp_in", want.avg_temp_in, rsp_data.avg_temp_in);
               if (rsp_data.avg_temp_out !== want.avg_temp_out)
                  flag_field("avg_temp_out", want.avg_temp_out, rsp_data.avg_temp_out);
               if (rsp_data.avg_wind !== want.avg_wind)
                  flag_field("avg_wind", want.avg_wind, rsp_data.avg_wind);
               if (rsp_data.peak_wind !== want.peak_wind)
                  flag_field("peak_wind", want.peak_wind, rsp_data.peak_wind);
               if (rsp_data.avg_light !== want.avg_light)
                  flag_field("avg_light", want.avg_light, rsp_data.avg_light);
               if (rsp_data.snap_valid !== want.snap_valid)
                  flag_field("snap_valid", want.snap_valid, rsp_data.snap_valid);
            end
            snaps_seen++;
         end
         if (req_valid && req_ready) begin
            case (req_data.action)
               ACT_SAMPLE: begin
                  samples_seen++;
                  if (req_data.temp_valid && temp_samples < MAX_SAMPLES) begin
                     indoor_sum   = indoor_sum + req_data.temp_in;
                     outdoor_sum  = outdoor_sum + req_data.temp_out;
                     temp_samples = temp_samples + 16'd1;
                  end
                  if (samples < MAX_SAMPLES) begin
                     wind_total  = wind_total + req_data.wind_speed;
                     light_total = light_total + req_data.light_level;
                     samples     = samples + 16'd1;
                  end
                  if (req_data.wind_speed > wind_max) wind_max = req_data.wind_speed;
               end
               ACT_CLEAR: begin
                  indoor_sum   = '0;
                  outdoor_sum  = '0;
                  temp_samples = '0;
                  samples      = '0;
                  wind_total   = '0;
                  light_total  = '0;
                  wind_max     = '0;
               end
               ACT_FINALIZE: begin
                  want.snap_time    = req_data.timestamp;
                  want.avg_temp_in  = temp_mean(indoor_sum, temp_samples);
                  want.avg_temp_out = temp_mean(outdoor_sum, temp_samples);
                  want.avg_wind     = (samples == 0) ? '0 : 14'(wind_total / samples);
                  want.peak_wind    = wind_max;
                  want.avg_light    = (samples == 0) ? '0 : 10'(light_total / samples);
                  want.snap_valid   = (samples != 0) || (temp_samples != 0);
                  snap_q.push_back(want);
               end
               default: ;
            endcase
         end
         snaps_due <= snap_q.size();
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top
   import wsa_pkg::*;
();

   localparam int          RANDOM_ITEMS = 650;
   localparam int          HOLD_CYCLES  = 800;
   localparam int          DRAIN_CYCLES = 80;
   localparam longint      CYCLE_LIMIT  = 1500000;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int     fail_count;
   int     snaps_due;
   int     snaps_seen;
   int     samples_seen;
   int     hold_asked = 0;
   int     hold_given = 0;
   int     total_reqs = 0;
   bit     no_gaps    = 1'b0;
   longint cycles     = 0;

   weather_sample_aggregator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   wsa_snapshot_checker snap_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .snaps_due    (snaps_due),
      .snaps_seen   (snaps_seen),
      .samples_seen (samples_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send(req_type r);
      int pick;
      int gap;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      total_reqs++;
      gap  = 0;
      pick = $urandom_range(0, 99);
      if (!no_gaps) begin
         if (pick >= 97)      gap = $urandom_range(30, 120);
         else if (pick >= 85) gap = $urandom_range(4, 20);
         else if (pick >= 50) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type junk_req();
      logic [95:0] junk;
      junk = {$urandom, $urandom, $urandom};
      return junk[$bits(req_type)-1:0];
   endfunction

   task automatic do_sample(bit tv, int tin, int tout, int wind, int light);
      req_type r;
      r             = junk_req();
      r.action      = ACT_SAMPLE;
      r.temp_valid  = tv;
      r.temp_in     = 12'(tin);
      r.temp_out    = 12'(tout);
      r.wind_speed  = 14'(wind);
      r.light_level = 10'(light);
      send(r);
   endtask

   task automatic do_finalize(logic [31:0] stamp);
      req_type r;
      r           = junk_req();
      r.action    = ACT_FINALIZE;
      r.timestamp = stamp;
      send(r);
   endtask

   task automatic do_clear();
      req_type r;
      r        = junk_req();
      r.action = ACT_CLEAR;
      send(r);
   endtask

   task automatic do_noise();
      req_type r;
      r        = junk_req();
      r.action = ACT_UNUSED;
      send(r);
   endtask

   task automatic random_sample(bit extreme);
      int tin;
      int tout;
      if (extreme) begin
         tin  = int'($urandom_range(0, 4095)) - 2048;
         tout = int'($urandom_range(0, 4095)) - 2048;
      end else begin
         tin  = int'($urandom_range(0, 2880)) - 880;
         tout = int'($urandom_range(0, 2880)) - 880;
      end
      do_sample($urandom_range(0, 3) != 0, tin, tout,
                $urandom_range(0, 16383), $urandom_range(0, 1023));
   endtask

   // receiver: random stalls, plus a long hold-off when the sender asks for one
   initial begin : ready_driver
      int pick;
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked != hold_given) begin
            hold_given++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_ready <= 1'b1;
               n = $urandom_range(1, 40);
            end else begin
               rsp_ready <= 1'b0;
               if (pick < 88)      n = $urandom_range(1, 3);
               else if (pick < 97) n = $urandom_range(4, 30);
               else                n = $urandom_range(50, 150);
            end
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int  counted;
      int  n;
      int  pick;
      bit  extreme;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      do_finalize(32'h0000_0000);
      do_sample(1'b0, 2047, -2048, 16383, 1023);
      do_finalize(32'hFFFF_FFFF);
      do_clear();
      do_finalize($urandom);
      do_sample(1'b1, 2047, -2048, 0, 0);
      do_finalize($urandom);
      do_clear();
      do_sample(1'b1, 2, -2, 5, 7);
      do_finalize($urandom);
      do_clear();
      do_sample(1'b1, -880, 2000, 1, 1);
      do_finalize($urandom);
      do_clear();
      do_sample(1'b1, -881, 1999, 3, 2);
      do_sample(1'b1, -880, 2000, 0, 1);
      do_finalize($urandom);
      do_noise();
      do_finalize($urandom);
      do_clear();

      // back up the output: finalizes keep coming while the receiver holds off
      hold_asked++;
      no_gaps = 1'b1;
      repeat (8) begin
         random_sample(1'b0);
         do_finalize($urandom);
      end
      no_gaps = 1'b0;
      do_clear();

      // random periods
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            do_clear();
            counted++;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0)      n = 0;
         else if (pick < 17) n = $urandom_range(1, 12);
         else                n = $urandom_range(13, 60);
         extreme = ($urandom_range(0, 5) == 0);
         repeat (n) begin
            if ($urandom_range(0, 24) == 0) do_noise();
            random_sample(extreme);
            counted++;
         end
         do_finalize($urandom);
         counted++;
         if ($urandom_range(0, 9) == 0) begin
            do_finalize($urandom);
            counted++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (snaps_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run sent %0d requests (%0d samples) and checked %0d snapshots,",
               total_reqs, samples_seen, snaps_seen);
      $display("covering rounding edges, empty periods, unused actions and output stalls.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/wsa_pkg.sv
rtl/wsa_ctrl.sv
rtl/wsa_dp.sv
rtl/weather_sample_aggregator.sv
tb/wsa_snapshot_checker.sv
tb/tb_top.sv
